/* hw/rtl/line_rect_clipper_defines.svh */
// Assertion macros of the line_rect_clipper RTL, used by lrc_queue.
`ifndef LINE_RECT_CLIPPER_DEFINES_SVH
`define LINE_RECT_CLIPPER_DEFINES_SVH

// Property that must hold at every rising clock edge out of reset.
`define LRC_ASSERT_NOW(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define LRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/lrc_pkg.sv */
// Shared constants and types of the line rectangle clipper.
package lrc_pkg;

  localparam int COORD_WIDTH_DEF     = 24;
  localparam int PARAM_FRAC_BITS_DEF = 16;
  localparam int Z_WIDTH             = 32;
  localparam int PIX_FRAC            = 8;
  localparam int BOUND_WIDTH         = 16;
  localparam int LIMIT_WIDTH         = BOUND_WIDTH + PIX_FRAC;
  localparam int REG_IDX_WIDTH       = 2;
  localparam int QUEUE_DEPTH         = 4;

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_BOUND_LEFT   = 2'd0,
    REG_BOUND_TOP    = 2'd1,
    REG_BOUND_RIGHT  = 2'd2,
    REG_BOUND_BOTTOM = 2'd3
  } lrc_reg_e;

endpackage

/* hw/rtl/lrc_if.sv */
// Channel interfaces: segment in, result out, and classified word between front and back.
interface lrc_seg_if import lrc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                      valid;
  logic                      ready;
  logic signed [CW-1:0]      start_x;
  logic signed [CW-1:0]      start_y;
  logic signed [Z_WIDTH-1:0] start_z;
  logic signed [CW-1:0]      end_x;
  logic signed [CW-1:0]      end_y;
  logic signed [Z_WIDTH-1:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z, input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z, output ready);
endinterface

interface lrc_res_if import lrc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                      valid;
  logic                      ready;
  logic                      visible;
  logic signed [CW-1:0]      clip_start_x;
  logic signed [CW-1:0]      clip_start_y;
  logic signed [Z_WIDTH-1:0] clip_start_z;
  logic signed [CW-1:0]      clip_end_x;
  logic signed [CW-1:0]      clip_end_y;
  logic signed [Z_WIDTH-1:0] clip_end_z;

  modport source (output valid, visible, clip_start_x, clip_start_y, clip_start_z,
                  clip_end_x, clip_end_y, clip_end_z, input ready);
  modport sink   (input valid, visible, clip_start_x, clip_start_y, clip_start_z,
                  clip_end_x, clip_end_y, clip_end_z, output ready);
endinterface

interface lrc_cls_if import lrc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int LW = CW + 2
);
  logic                      valid;
  logic                      ready;
  logic signed [CW-1:0]      sx;
  logic signed [CW-1:0]      sy;
  logic signed [Z_WIDTH-1:0] sz;
  logic signed [CW:0]        dx;
  logic signed [CW:0]        dy;
  logic signed [Z_WIDTH:0]   dz;
  logic [1:0][LW-1:0]        num_lo;
  logic [1:0][LW-1:0]        num_hi;
  logic [1:0][CW:0]          den;
  logic [1:0]                neg_lo;
  logic [1:0]                neg_hi;
  logic [1:0]                dzero;
  logic [1:0]                in_box;
  logic                      empty;

  modport source (output valid, sx, sy, sz, dx, dy, dz, num_lo, num_hi, den, neg_lo, neg_hi,
                  dzero, in_box, empty, input ready);
  modport sink   (input valid, sx, sy, sz, dx, dy, dz, num_lo, num_hi, den, neg_lo, neg_hi,
                  dzero, in_box, empty, output ready);
endinterface

/* hw/rtl/line_rect_clipper.sv */
// Top level of the Liang-Barsky segment clipper against a pixel rectangle.
//
//   channel | dir | handshake          | word
//   seg     | in  | valid/ready        | start and end x, y, z of one segment
//   res     | out | valid/ready        | visible flag and clipped endpoints
//   cfg     | in  | cfg_we_i, no ready | one bound register per write
//
// One segment per cycle sustained while results are taken; a result word passes,
// after its segment is accepted, through the front register, a queue slot, one divider
// stage per quotient bit, then four stages of select and interpolate.
// Reset clears all valid state and loads the bounds to 0, 0, 65535, 65535.
// A stalled result freezes the back end; the front end keeps accepting into a
// four-word queue and stalls only when that queue is full.
module line_rect_clipper import lrc_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [REG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [BOUND_WIDTH-1:0]   cfg_data_i,
  lrc_seg_if.sink                  seg,
  lrc_res_if.source                res
);

  // signed width of a limit minus a start coordinate
  localparam int LW = ((COORD_WIDTH > LIMIT_WIDTH + 1) ? COORD_WIDTH : LIMIT_WIDTH + 1) + 1;

  lrc_cls_if #(.CW(COORD_WIDTH), .LW(LW)) f2q_if ();
  lrc_cls_if #(.CW(COORD_WIDTH), .LW(LW)) q2b_if ();

  lrc_front #(
    .CW (COORD_WIDTH),
    .LW (LW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .seg        (seg),
    .cls        (f2q_if.source)
  );

  lrc_queue #(
    .CW (COORD_WIDTH),
    .LW (LW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr     (f2q_if.sink),
    .rd     (q2b_if.source)
  );

  lrc_back #(
    .CW  (COORD_WIDTH),
    .LW  (LW),
    .PFB (PARAM_FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cls    (q2b_if.sink),
    .res    (res)
  );

endmodule

/* hw/rtl/lrc_front.sv */
// Front end: bound registers, segment intake and per-axis classification.
module lrc_front import lrc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int LW = CW + 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [REG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [BOUND_WIDTH-1:0]   cfg_data_i,
  lrc_seg_if.sink                  seg,
  lrc_cls_if.source                cls
);

  logic [BOUND_WIDTH-1:0] bl_q, bt_q, br_q, bb_q;
  logic [BOUND_WIDTH-1:0] br_m1, bb_m1;
  logic [LIMIT_WIDTH-1:0] lim_lo [2];
  logic [LIMIT_WIDTH-1:0] lim_hi [2];
  logic signed [CW-1:0]   s [2];
  logic signed [CW-1:0]   e [2];
  logic signed [CW:0]     dlt [2];
  logic signed [LW-1:0]   dl_lo [2];
  logic signed [LW-1:0]   dl_hi [2];

  logic                      load;
  logic                      v_q;
  logic signed [CW-1:0]      sx_q, sy_q;
  logic signed [Z_WIDTH-1:0] sz_q;
  logic signed [CW:0]        dx_q, dy_q;
  logic signed [Z_WIDTH:0]   dz_q;
  logic [1:0][LW-1:0]        nlo_d, nhi_d, nlo_q, nhi_q;
  logic [1:0][CW:0]          den_d, den_q;
  logic [1:0]                neglo_d, neghi_d, dzero_d, in_box_d;
  logic [1:0]                neglo_q, neghi_q, dzero_q, in_box_q;
  logic                      empty_d, empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_q <= '0;
      bt_q <= '0;
      br_q <= '1;
      bb_q <= '1;
    end else if (cfg_we_i) begin
      case (lrc_reg_e'(cfg_idx_i))
        REG_BOUND_LEFT:   bl_q <= cfg_data_i;
        REG_BOUND_TOP:    bt_q <= cfg_data_i;
        REG_BOUND_RIGHT:  br_q <= cfg_data_i;
        REG_BOUND_BOTTOM: bb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign br_m1 = br_q - BOUND_WIDTH'(1);
  assign bb_m1 = bb_q - BOUND_WIDTH'(1);

  always_comb begin
    lim_lo[0] = {bl_q, {PIX_FRAC{1'b0}}};
    lim_lo[1] = {bt_q, {PIX_FRAC{1'b0}}};
    lim_hi[0] = {br_m1, {PIX_FRAC{1'b0}}};
    lim_hi[1] = {bb_m1, {PIX_FRAC{1'b0}}};
    s[0] = seg.start_x;
    s[1] = seg.start_y;
    e[0] = seg.end_x;
    e[1] = seg.end_y;
    // inclusive maximum is edge-1, so an edge at or below the minimum is empty
    empty_d = (br_q <= bl_q) || (bb_q <= bt_q);
    for (int a = 0; a < 2; a++) begin
      dlt[a]   = (CW+1)'(e[a]) - (CW+1)'(s[a]);
      dl_lo[a] = LW'($signed({1'b0, lim_lo[a]})) - LW'(s[a]);
      dl_hi[a] = LW'($signed({1'b0, lim_hi[a]})) - LW'(s[a]);
      nlo_d[a] = dl_lo[a][LW-1] ? LW'(-dl_lo[a]) : LW'(dl_lo[a]);
      nhi_d[a] = dl_hi[a][LW-1] ? LW'(-dl_hi[a]) : LW'(dl_hi[a]);
      den_d[a] = dlt[a][CW] ? (CW+1)'(-dlt[a]) : (CW+1)'(dlt[a]);
      neglo_d[a]  = dl_lo[a][LW-1] ^ dlt[a][CW];
      neghi_d[a]  = dl_hi[a][LW-1] ^ dlt[a][CW];
      dzero_d[a]  = (dlt[a] == '0);
      in_box_d[a] = (dl_lo[a][LW-1] || (dl_lo[a] == '0)) && !dl_hi[a][LW-1];
    end
  end

  assign seg.ready = !v_q || cls.ready;
  assign load      = seg.valid && seg.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (seg.ready) begin
      v_q <= seg.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sx_q     <= seg.start_x;
      sy_q     <= seg.start_y;
      sz_q     <= seg.start_z;
      dx_q     <= dlt[0];
      dy_q     <= dlt[1];
      dz_q     <= (Z_WIDTH+1)'(seg.end_z) - (Z_WIDTH+1)'(seg.start_z);
      nlo_q    <= nlo_d;
      nhi_q    <= nhi_d;
      den_q    <= den_d;
      neglo_q  <= neglo_d;
      neghi_q  <= neghi_d;
      dzero_q  <= dzero_d;
      in_box_q <= in_box_d;
      empty_q  <= empty_d;
    end
  end

  assign cls.valid  = v_q;
  assign cls.sx     = sx_q;
  assign cls.sy     = sy_q;
  assign cls.sz     = sz_q;
  assign cls.dx     = dx_q;
  assign cls.dy     = dy_q;
  assign cls.dz     = dz_q;
  assign cls.num_lo = nlo_q;
  assign cls.num_hi = nhi_q;
  assign cls.den    = den_q;
  assign cls.neg_lo = neglo_q;
  assign cls.neg_hi = neghi_q;
  assign cls.dzero  = dzero_q;
  assign cls.in_box = in_box_q;
  assign cls.empty  = empty_q;

endmodule

/* hw/rtl/lrc_queue.sv */
// Short queue of classified words between the front and back ends.
`include "line_rect_clipper_defines.svh"

module lrc_queue import lrc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int LW = CW + 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lrc_cls_if.sink    wr,
  lrc_cls_if.source  rd
);

  localparam int IW   = 2*CW + Z_WIDTH + 2*(CW+1) + (Z_WIDTH+1) + 4*LW + 2*(CW+1) + 9;
  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  logic [IW-1:0]   mem [QUEUE_DEPTH];
  logic [IW-1:0]   wdata;
  logic [PW-1:0]   wp_q, rp_q;
  logic [CNTW-1:0] cnt_q;
  logic            push, pop;

  assign wdata = {wr.sx, wr.sy, wr.sz, wr.dx, wr.dy, wr.dz, wr.num_lo, wr.num_hi, wr.den,
                  wr.neg_lo, wr.neg_hi, wr.dzero, wr.in_box, wr.empty};
  assign {rd.sx, rd.sy, rd.sz, rd.dx, rd.dy, rd.dz, rd.num_lo, rd.num_hi, rd.den,
          rd.neg_lo, rd.neg_hi, rd.dzero, rd.in_box, rd.empty} = mem[rp_q];

  assign wr.ready = (cnt_q != CNTW'(QUEUE_DEPTH));
  assign rd.valid = (cnt_q != '0);
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wp_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + PW'(1);
      end
      if (pop) begin
        rp_q <= rp_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  `LRC_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNTW'(QUEUE_DEPTH), "queue count overrun")
  `LRC_ASSERT_NOW(a_ptr_gap, clk_i, rst_ni, PW'(wp_q - rp_q) == cnt_q[PW-1:0], "pointer gap off")
  `LRC_ASSERT_NEXT(a_cnt_up, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + CNTW'(1), "push lost")
  `LRC_ASSERT_NEXT(a_cnt_dn, clk_i, rst_ni, pop && !push, cnt_q == $past(cnt_q) - CNTW'(1), "pop lost")

endmodule

/* hw/rtl/lrc_back.sv */
// Back end: pipelined parameter division, entry/exit selection and endpoint interpolation.
module lrc_back import lrc_pkg::*; #(
  parameter int CW  = COORD_WIDTH_DEF,
  parameter int LW  = CW + 2,
  parameter int PFB = PARAM_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrc_cls_if.sink     cls,
  lrc_res_if.source   res
);

  localparam int NS  = PFB + 1;
  localparam int RW  = CW + 2;
  localparam int TW  = PFB + 3;
  localparam int OW  = (LW > RW) ? LW : RW;
  localparam int PCW = CW + PFB + 3;
  localparam int PZW = Z_WIDTH + PFB + 3;

  localparam logic signed [TW-1:0]  T_ONE  = TW'(1) << PFB;
  localparam logic signed [TW-1:0]  T_OVER = T_ONE + TW'(1);
  localparam logic signed [TW-1:0]  T_NEG  = '1;
  localparam logic signed [PCW-1:0] C_BIAS = (PCW'(1) << PFB) - PCW'(1);
  localparam logic signed [PZW-1:0] Z_BIAS = (PZW'(1) << PFB) - PZW'(1);

  typedef struct packed {
    logic signed [CW-1:0]      sx;
    logic signed [CW-1:0]      sy;
    logic signed [Z_WIDTH-1:0] sz;
    logic signed [CW:0]        dx;
    logic signed [CW:0]        dy;
    logic signed [Z_WIDTH:0]   dz;
    logic [1:0][CW:0]          den;
    logic [3:0]                neg;
    logic [3:0]                ovf;
    logic [1:0]                dzero;
    logic [1:0]                in_box;
    logic                      empty;
  } div_pl_t;

  logic adv;

  // lanes: 0 x low edge, 1 x high edge, 2 y low edge, 3 y high edge
  div_pl_t            pl0;
  logic [3:0][RW-1:0] rem0;
  logic [3:0][LW-1:0] num0;

  logic [NS-1:0]      dv_q;
  div_pl_t            dpl_q [NS];
  logic [3:0][RW-1:0] rem_q [NS];
  logic [3:0][PFB:0]  quo_q [NS];
  logic [3:0][RW-1:0] r_out [NS];
  logic [3:0][PFB:0]  q_out [NS];

  logic signed [TW-1:0] tl [4];
  logic signed [TW-1:0] ta_d [2];
  logic signed [TW-1:0] tb_d [2];
  logic signed [TW-1:0] ta_q [2];
  logic signed [TW-1:0] tb_q [2];
  logic                 r1v_q;
  div_pl_t              r1pl_q;

  logic signed [TW-1:0] ent_d, ext_d;
  logic                 vis_d;
  logic [PFB:0]         ent_q, ext_q;
  logic                 vis_q, r2v_q;
  div_pl_t              r2pl_q;

  logic signed [PFB+1:0]  te_s, tx_s;
  logic signed [PCW-1:0]  pc_d [4];
  logic signed [PCW-1:0]  pc_q [4];
  logic signed [PZW-1:0]  pz_d [2];
  logic signed [PZW-1:0]  pz_q [2];
  logic                   mvis_q, mv_q;
  div_pl_t                mpl_q;

  logic signed [PCW-1:0]     cb [4];
  logic signed [PZW-1:0]     zb [2];
  logic signed [CW-1:0]      cres [4];
  logic signed [Z_WIDTH-1:0] zres [2];
  logic                      ov_q, ovis_q;
  logic signed [CW-1:0]      ocx_q [4];
  logic signed [Z_WIDTH-1:0] ocz_q [2];

  assign adv       = !ov_q || res.ready;
  assign cls.ready = adv;

  always_comb begin
    pl0.sx     = cls.sx;
    pl0.sy     = cls.sy;
    pl0.sz     = cls.sz;
    pl0.dx     = cls.dx;
    pl0.dy     = cls.dy;
    pl0.dz     = cls.dz;
    pl0.den    = cls.den;
    pl0.dzero  = cls.dzero;
    pl0.in_box = cls.in_box;
    pl0.empty  = cls.empty;
    for (int a = 0; a < 2; a++) begin
      num0[2*a]      = cls.num_lo[a];
      num0[2*a+1]    = cls.num_hi[a];
      pl0.neg[2*a]   = cls.neg_lo[a];
      pl0.neg[2*a+1] = cls.neg_hi[a];
    end
    for (int j = 0; j < 4; j++) begin
      // quotient reaches two or more: clamp, no digits needed
      pl0.ovf[j] = OW'(num0[j]) >= OW'({cls.den[j >> 1], 1'b0});
      rem0[j]    = RW'(num0[j]);
    end
  end

  // one restoring quotient bit per stage, four lanes side by side
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [3:0][RW-1:0] r_in;
    logic [3:0][PFB:0]  q_in;
    div_pl_t            dp_in;
    if (k == 0) begin : g_head
      assign r_in  = rem0;
      assign q_in  = '0;
      assign dp_in = pl0;
    end else begin : g_body
      assign r_in  = rem_q[k-1];
      assign q_in  = quo_q[k-1];
      assign dp_in = dpl_q[k-1];
    end
    always_comb begin
      for (int j = 0; j < 4; j++) begin
        if (r_in[j] >= RW'(dp_in.den[j >> 1])) begin
          r_out[k][j] = RW'((r_in[j] - RW'(dp_in.den[j >> 1])) << 1);
          q_out[k][j] = {q_in[j][PFB-1:0], 1'b1};
        end else begin
          r_out[k][j] = RW'(r_in[j] << 1);
          q_out[k][j] = {q_in[j][PFB-1:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k] <= r_out[k];
        quo_q[k] <= q_out[k];
        dpl_q[k] <= dp_in;
      end
    end
  end

  // clamp quotients to [-1, one+1] and order them per axis
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (dpl_q[NS-1].neg[j]) begin
        tl[j] = (dpl_q[NS-1].ovf[j] || (quo_q[NS-1][j] != '0)) ? T_NEG : '0;
      end else if (dpl_q[NS-1].ovf[j] || ($signed(TW'(quo_q[NS-1][j])) > T_OVER)) begin
        tl[j] = T_OVER;
      end else begin
        tl[j] = $signed(TW'(quo_q[NS-1][j]));
      end
    end
    for (int a = 0; a < 2; a++) begin
      if (dpl_q[NS-1].dzero[a]) begin
        ta_d[a] = '0;
        tb_d[a] = T_ONE;
      end else if (tl[2*a] > tl[2*a+1]) begin
        ta_d[a] = tl[2*a+1];
        tb_d[a] = tl[2*a];
      end else begin
        ta_d[a] = tl[2*a];
        tb_d[a] = tl[2*a+1];
      end
    end
  end

  always_comb begin
    ent_d = (ta_q[0] > ta_q[1]) ? ta_q[0] : ta_q[1];
    if (ent_d < 0) begin
      ent_d = '0;
    end
    ext_d = (tb_q[0] < tb_q[1]) ? tb_q[0] : tb_q[1];
    if (ext_d > T_ONE) begin
      ext_d = T_ONE;
    end
    vis_d = !r1pl_q.empty && (!r1pl_q.dzero[0] || r1pl_q.in_box[0]) &&
            (!r1pl_q.dzero[1] || r1pl_q.in_box[1]) && (ent_d <= ext_d);
  end

  always_comb begin
    te_s    = $signed({1'b0, ent_q});
    tx_s    = $signed({1'b0, ext_q});
    pc_d[0] = r2pl_q.dx * te_s;
    pc_d[1] = r2pl_q.dy * te_s;
    pc_d[2] = r2pl_q.dx * tx_s;
    pc_d[3] = r2pl_q.dy * tx_s;
    pz_d[0] = r2pl_q.dz * te_s;
    pz_d[1] = r2pl_q.dz * tx_s;
  end

  // truncate toward zero: bias negative products before the arithmetic shift
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cb[i]   = pc_q[i] + (pc_q[i][PCW-1] ? C_BIAS : PCW'(0));
      cres[i] = ((i % 2) == 0 ? mpl_q.sx : mpl_q.sy) + CW'(cb[i] >>> PFB);
    end
    for (int i = 0; i < 2; i++) begin
      zb[i]   = pz_q[i] + (pz_q[i][PZW-1] ? Z_BIAS : PZW'(0));
      zres[i] = mpl_q.sz + Z_WIDTH'(zb[i] >>> PFB);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ta_q   <= ta_d;
      tb_q   <= tb_d;
      r1pl_q <= dpl_q[NS-1];
      ent_q  <= ent_d[PFB:0];
      ext_q  <= ext_d[PFB:0];
      vis_q  <= vis_d;
      r2pl_q <= r1pl_q;
      pc_q   <= pc_d;
      pz_q   <= pz_d;
      mvis_q <= vis_q;
      mpl_q  <= r2pl_q;
      ovis_q <= mvis_q;
      for (int i = 0; i < 4; i++) begin
        ocx_q[i] <= mvis_q ? cres[i] : '0;
      end
      for (int i = 0; i < 2; i++) begin
        ocz_q[i] <= mvis_q ? zres[i] : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q  <= '0;
      r1v_q <= 1'b0;
      r2v_q <= 1'b0;
      mv_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else if (adv) begin
      dv_q  <= {dv_q[NS-2:0], cls.valid};
      r1v_q <= dv_q[NS-1];
      r2v_q <= r1v_q;
      mv_q  <= r2v_q;
      ov_q  <= mv_q;
    end
  end

  assign res.valid        = ov_q;
  assign res.visible      = ovis_q;
  assign res.clip_start_x = ocx_q[0];
  assign res.clip_start_y = ocx_q[1];
  assign res.clip_end_x   = ocx_q[2];
  assign res.clip_end_y   = ocx_q[3];
  assign res.clip_start_z = ocz_q[0];
  assign res.clip_end_z   = ocz_q[1];

endmodule

/* tb/sv/tb.sv */
// Testbench for line_rect_clipper: segment stream against a predictor of the clipped result.
`timescale 1ns / 1ps

module tb import lrc_pkg::*; ();

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FRAC = PARAM_FRAC_BITS_DEF;
  localparam int LATENCY = FRAC + 7;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CW-1:0]      sx;
    logic signed [CW-1:0]      sy;
    logic signed [Z_WIDTH-1:0] sz;
    logic signed [CW-1:0]      ex;
    logic signed [CW-1:0]      ey;
    logic signed [Z_WIDTH-1:0] ez;
  } segment_t;

  typedef struct packed {
    logic                      visible;
    logic signed [CW-1:0]      csx;
    logic signed [CW-1:0]      csy;
    logic signed [Z_WIDTH-1:0] csz;
    logic signed [CW-1:0]      cex;
    logic signed [CW-1:0]      cey;
    logic signed [Z_WIDTH-1:0] cez;
  } clip_t;

  class clip_scoreboard;
    longint left, top, right, bottom;
    clip_t  pending[$];
    int     errors;
    int     n_seg;
    int     n_visible;

    function new();
      left = 0; top = 0; right = 65535; bottom = 65535;
      errors = 0; n_seg = 0; n_visible = 0;
    endfunction

    function void set_bound(lrc_reg_e idx, logic [BOUND_WIDTH-1:0] val);
      case (idx)
        REG_BOUND_LEFT:   left = val;
        REG_BOUND_TOP:    top = val;
        REG_BOUND_RIGHT:  right = val;
        REG_BOUND_BOTTOM: bottom = val;
        default: ;
      endcase
    endfunction

    // Narrows [t_in, t_out] by one axis; returns 0 if rejected.
    function bit narrow(longint st, longint dl, longint lo, longint hi,
                        inout longint t_in, inout longint t_out);
      longint ta, tb, tmp;
      if (dl == 0) return (st >= lo) && (st <= hi);
      ta = ((lo - st) * (longint'(1) << FRAC)) / dl;
      tb = ((hi - st) * (longint'(1) << FRAC)) / dl;
      if (ta > tb) begin
        tmp = ta; ta = tb; tb = tmp;
      end
      if (ta > t_in) t_in = ta;
      if (tb < t_out) t_out = tb;
      return t_in <= t_out;
    endfunction

    function longint interp(longint a, longint b, longint t);
      return a + ((b - a) * t) / (longint'(1) << FRAC);
    endfunction

    function void note_segment(segment_t s);
      clip_t  r;
      longint sx, sy, sz, ex, ey, ez, t_in, t_out;
      sx = s.sx; sy = s.sy; sz = s.sz; ex = s.ex; ey = s.ey; ez = s.ez;
      t_in = 0;
      t_out = longint'(1) << FRAC;
      r = '0;
      n_seg++;
      if (right - 1 >= left && bottom - 1 >= top &&
          narrow(sx, ex - sx, left * 256, (right - 1) * 256, t_in, t_out) &&
          narrow(sy, ey - sy, top * 256, (bottom - 1) * 256, t_in, t_out)) begin
        r.visible = 1'b1;
        r.csx = CW'(interp(sx, ex, t_in));
        r.csy = CW'(interp(sy, ey, t_in));
        r.csz = Z_WIDTH'(interp(sz, ez, t_in));
        r.cex = CW'(interp(sx, ex, t_out));
        r.cey = CW'(interp(sy, ey, t_out));
        r.cez = Z_WIDTH'(interp(sz, ez, t_out));
        n_visible++;
      end
      pending.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t: mismatch on %s: expected %h, got %h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(clip_t a);
      clip_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("visible", e.visible, a.visible);
      cmp("clip_start_x", e.csx, a.csx);
      cmp("clip_start_y", e.csy, a.csy);
      cmp("clip_start_z", e.csz, a.csz);
      cmp("clip_end_x", e.cex, a.cex);
      cmp("clip_end_y", e.cey, a.cey);
      cmp("clip_end_z", e.cez, a.cez);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [REG_IDX_WIDTH-1:0] cfg_idx_i = '0;
  logic [BOUND_WIDTH-1:0]   cfg_data_i = '0;
  int   cycles = 0;
  bit   no_idle = 0;
  int   hold_req = 0;

  lrc_seg_if #(.CW(CW)) seg_ch ();
  lrc_res_if #(.CW(CW)) res_ch ();

  clip_scoreboard sb = new();

  line_rect_clipper uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .seg        (seg_ch),
    .res        (res_ch)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending.size());
      $display("line_rect_clipper test failed");
      $finish;
    end
  end

  // result side: check on the rising edge, move ready on the falling edge
  initial begin
    int held;
    held = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready)
        sb.check_result({res_ch.visible, res_ch.clip_start_x, res_ch.clip_start_y,
                         res_ch.clip_start_z, res_ch.clip_end_x, res_ch.clip_end_y,
                         res_ch.clip_end_z});
      @(negedge clk_i);
      if (hold_req > 0 && held == 0) begin
        held = hold_req;
        hold_req = 0;
      end
      if (held > 0) begin
        held--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= no_idle || ($urandom_range(99) >= 12);
      end
    end
  end

  task automatic send_segment(segment_t s);
    while (!no_idle && $urandom_range(99) < 12) begin
      @(negedge clk_i);
      seg_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    seg_ch.valid   <= 1'b1;
    seg_ch.start_x <= s.sx;
    seg_ch.start_y <= s.sy;
    seg_ch.start_z <= s.sz;
    seg_ch.end_x   <= s.ex;
    seg_ch.end_y   <= s.ey;
    seg_ch.end_z   <= s.ez;
    do @(posedge clk_i); while (!seg_ch.ready);
    sb.note_segment(s);
  endtask

  task automatic drain();
    @(negedge clk_i);
    seg_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_bound(lrc_reg_e idx, logic [BOUND_WIDTH-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_bound(idx, val);
  endtask

  task automatic set_rect(int l, int t, int r, int b);
    write_bound(REG_BOUND_LEFT, BOUND_WIDTH'(l));
    write_bound(REG_BOUND_TOP, BOUND_WIDTH'(t));
    write_bound(REG_BOUND_RIGHT, BOUND_WIDTH'(r));
    write_bound(REG_BOUND_BOTTOM, BOUND_WIDTH'(b));
  endtask

  // coordinate in Q16.8 around [lo, hi] pixels, clamped to the field range
  function automatic logic [CW-1:0] near_coord(longint lo, longint hi);
    longint v;
    v = (lo - 40 + longint'($urandom_range(hi - lo + 80))) * 256;
    if ($urandom_range(3) != 0) v += $urandom_range(255);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return CW'(v);
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    int mode;
    mode = $urandom_range(99);
    s.sz = $urandom();
    s.ez = $urandom();
    if (mode < 15 || sb.right - sb.left > 30000) begin
      s.sx = CW'($urandom()); s.sy = CW'($urandom());
      s.ex = CW'($urandom()); s.ey = CW'($urandom());
      if (sb.right - sb.left > 30000 && mode >= 15) begin
        // pull start x and end y toward the origin corner so some segments land inside
        s.sx = CW'($urandom_range(2000000)); s.ey = CW'($urandom_range(2000000));
      end
    end else begin
      s.sx = near_coord(sb.left, sb.right);
      s.ex = near_coord(sb.left, sb.right);
      s.sy = near_coord(sb.top, sb.bottom);
      s.ey = near_coord(sb.top, sb.bottom);
    end
    // axis-parallel segments exercise the zero-delta test
    if ($urandom_range(9) == 0) s.ex = s.sx;
    if ($urandom_range(9) == 0) s.ey = s.sy;
    return s;
  endfunction

  task automatic random_run(int n);
    repeat (n) send_segment(random_segment());
  endtask

  localparam logic signed [CW-1:0] CMIN = -(1 <<< (CW - 1));
  localparam logic signed [CW-1:0] CMAX = (1 <<< (CW - 1)) - 1;
  localparam logic signed [31:0]   ZMIN = 32'h8000_0000;
  localparam logic signed [31:0]   ZMAX = 32'h7fff_ffff;

  initial begin
    seg_ch.valid = 1'b0;
    seg_ch.start_x = '0; seg_ch.start_y = '0; seg_ch.start_z = '0;
    seg_ch.end_x = '0; seg_ch.end_y = '0; seg_ch.end_z = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset bounds: field extremes, points, crossings
    send_segment('{CMIN, CMIN, ZMIN, CMAX, CMAX, ZMAX});
    send_segment('{CMAX, CMAX, ZMAX, CMIN, CMIN, ZMIN});
    send_segment('{CMAX, CMAX, ZMAX, CMAX, CMAX, ZMIN});
    send_segment('{24'sd1280, 24'sd2560, 32'sd65536, 24'sd1280, 24'sd2560, -32'sd65536});
    send_segment('{-24'sd256, 24'sd2560, 32'sd0, -24'sd256, 24'sd2560, 32'sd0});
    send_segment('{-24'sd5000, 24'sd100, ZMAX, 24'sd5000, 24'sd100, ZMIN});
    send_segment('{24'sd100, -24'sd5000, ZMIN, 24'sd100, 24'sd5000, ZMAX});
    send_segment('{24'sd0, 24'sd0, 32'sd0, 24'sd0, 24'sd0, 32'sd0});
    drain();

    set_rect(10, 20, 100, 80);
    send_segment('{24'sd3000, 24'sd6000, 32'sd100, 24'sd20000, 24'sd15000, 32'sd900000});
    send_segment('{24'sd0, 24'sd0, ZMIN, 24'sd30000, 24'sd25000, ZMAX});
    send_segment('{24'sd0, 24'sd0, 32'sd0, 24'sd2000, 24'sd30000, 32'sd0});
    // diagonal touching the corner: entry and exit parameters meet
    send_segment('{24'sd0, 24'sd10240, 32'sd0, 24'sd5120, 24'sd0, 32'sd7});
    send_segment('{24'sd5000, 24'sd0, 32'sd5, 24'sd5000, 24'sd30000, -32'sd5});
    send_segment('{24'sd1000, 24'sd0, 32'sd5, 24'sd1000, 24'sd30000, -32'sd5});
    send_segment('{24'sd2560, 24'sd5120, 32'sd1, 24'sd25344, 24'sd20224, 32'sd2});
    random_run(300);
    drain();

    // single pixel at origin, no idling on either side
    no_idle = 1;
    set_rect(0, 0, 1, 1);
    random_run(300);
    drain();
    no_idle = 0;

    // far corner beyond coordinate reach, then empty rectangles
    set_rect(65534, 65534, 65535, 65535);
    random_run(100);
    drain();
    set_rect(65535, 65535, 65535, 65535);
    random_run(60);
    drain();
    set_rect(0, 0, 0, 0);
    random_run(60);
    drain();
    set_rect(50, 10, 200, 10);
    random_run(60);
    drain();

    // moderate box; result side holds off so the input queue fills
    set_rect(300, 200, 2000, 1500);
    random_run(150);
    hold_req = 80;
    random_run(200);
    drain();

    set_rect(0, 0, 65535, 65535);
    random_run(300);
    drain();

    set_rect(7, 3, 40, 25);
    random_run(300);
    drain();

    $display("clipped %0d segments over 10 rectangle settings, %0d visible",
             sb.n_seg, sb.n_visible);
    $display("including empty and single-pixel boxes, axis-parallel and full-range segments");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("line_rect_clipper test passed");
    end else begin
      $display("line_rect_clipper test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/lrc_pkg.sv
hw/rtl/lrc_if.sv
hw/rtl/lrc_front.sv
hw/rtl/lrc_queue.sv
hw/rtl/lrc_back.sv
hw/rtl/line_rect_clipper.sv
tb/sv/tb.sv
